// File: sv/esm_pkg.sv
// Shared types, widths and constants for the encoder speed and stall monitor.
`default_nettype none

package esm_pkg;

    // Encoder counter width used for the wrapped difference.
    localparam int COUNT_WIDTH = 16;

    localparam int CFG_W   = 16;
    localparam int CPR_W   = 13;
    localparam int WIN_W   = 16;
    localparam int MIN_W   = 16;
    localparam int DT_W    = 16;
    localparam int TIME_W  = 32;
    localparam int ACC_W   = 16;
    localparam int SPEED_W = 16;
    localparam int SCALE_W = 16;

    // Divider operand widths: numerator is mag*60000, denominator cpr*dt.
    localparam int NUM_W     = COUNT_WIDTH + SCALE_W;
    localparam int DEN_W     = CPR_W + DT_W;
    localparam int MUL_A_W   = (COUNT_WIDTH > CPR_W) ? COUNT_WIDTH : CPR_W;
    localparam int MUL_P_W   = MUL_A_W + SCALE_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [SCALE_W-1:0] RPM_SCALE = 16'd60000;
    localparam logic [DT_W-1:0]    DT_MAX    = 16'hFFFF;

    localparam logic [CPR_W-1:0] CPR_RESET = 13'd44;
    localparam logic [WIN_W-1:0] WIN_RESET = 16'd500;
    localparam logic [MIN_W-1:0] MIN_RESET = 16'd3;

    localparam logic [NUM_W-1:0] SAT_POS = NUM_W'(32767);
    localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(32768);

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CPR    = 2'd0;
    localparam cfg_idx_t REG_WINDOW = 2'd1;
    localparam cfg_idx_t REG_MIN    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_DIV,
        ST_DONE
    } esm_state_t;

    typedef struct packed {
        logic start;
    } esm_div_ctrl_t;

    typedef struct packed {
        logic done;
        logic busy;
    } esm_div_stat_t;

    typedef struct packed {
        logic fault;
        logic online;
        logic closed;
    } esm_win_stat_t;

endpackage

`default_nettype wire

// File: sv/encoder_speed_and_stall_monitor.sv
// Top level of the encoder speed and stall monitor: sequencer, shared multiplier, output register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per control tick:
//   encoder_count, now_ms, link_ok, commanded_speed. An item is taken at a
//   clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns one item per input item:
//   speed_rpm, effective_target, stall_fault, drive_online, window_closed.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   write only while no item is in flight.
//   Steps: accept, the shared multiplier (numerator, then denominator), the
//   bit-serial divider, then saturation into the output register.
//   The next item is taken only from idle, after the current one has been
//   loaded into the output register.
//   in_stall is high whenever the sequencer is not idle.
//   A result waits in the output register while out_stall is high; the next
//   item can be taken meanwhile and holds in its final state until the
//   output register frees up.
//   Reset clears the previous count and time, the window start, the
//   accumulator and all three flags, and loads the register defaults
//   (44 counts per rev, 500 ms window, 3 counts minimum).
`default_nettype none

module encoder_speed_and_stall_monitor (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [15:0]              encoder_count,
    input  wire logic [31:0]              now_ms,
    input  wire logic                     link_ok,
    input  wire logic signed [15:0]       commanded_speed,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [15:0]            speed_rpm,
    output logic signed [15:0]            effective_target,
    output logic                          stall_fault,
    output logic                          drive_online,
    output logic                          window_closed,
    input  wire logic                     cfg_write,
    input  wire esm_pkg::cfg_idx_t        cfg_index,
    input  wire logic [esm_pkg::CFG_W-1:0] cfg_data
);
    import esm_pkg::*;

    // Configuration registers
    logic [CPR_W-1:0] cpr_reg;
    logic [WIN_W-1:0] win_reg;
    logic [MIN_W-1:0] min_reg;

    // Sequencer
    esm_state_t state_reg, state_next;
    logic       in_accept;
    logic       out_accept;
    logic       out_free;
    logic       num_load;
    logic       out_load;
    logic       mul_den_sel;
    esm_div_ctrl_t div_ctrl;
    esm_div_stat_t div_stat;
    esm_win_stat_t win_stat;

    // Per-item working registers
    logic [COUNT_WIDTH-1:0] prev_count_reg;
    logic [TIME_W-1:0]      prev_time_reg;
    logic [COUNT_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [DT_W-1:0]        dt_reg;
    logic [SPEED_W-1:0]     target_reg;
    logic [NUM_W-1:0]       num_reg;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]   speed_reg;
    logic [SPEED_W-1:0]   otarget_reg;
    logic                 ofault_reg;
    logic                 oonline_reg;
    logic                 oclosed_reg;

    // Item front end: wrapped difference, magnitude and clamped elapsed time
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] diff;
    logic                   diff_neg;
    logic [COUNT_WIDTH-1:0] diff_mag;
    logic [TIME_W-1:0]      dt_full;
    logic [DT_W-1:0]        dt_clamped;
    logic [SPEED_W-1:0]     target_bits;
    logic [CPR_W-1:0]       cpr_eff;

    // Shared multiplier and saturation
    logic [MUL_A_W-1:0] mul_a;
    logic [SCALE_W-1:0] mul_b;
    logic [MUL_P_W-1:0] product;
    logic [NUM_W-1:0]   quotient;
    logic [SPEED_W-1:0] rpm_bits;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    assign cnt         = COUNT_WIDTH'(encoder_count);
    assign diff        = cnt - prev_count_reg;
    assign diff_neg    = diff[COUNT_WIDTH-1];
    assign diff_mag    = diff_neg ? (~diff + 1'b1) : diff;
    assign dt_full     = now_ms - prev_time_reg;
    // Zero elapsed time counts as one, anything past 16 bits clamps.
    assign dt_clamped  = (dt_full == '0) ? DT_W'(1) :
                         ((|dt_full[TIME_W-1:DT_W]) ? DT_MAX : dt_full[DT_W-1:0]);
    assign target_bits = link_ok ? commanded_speed : '0;
    assign cpr_eff     = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= CPR_RESET;
            win_reg <= WIN_RESET;
            min_reg <= MIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CPR:    cpr_reg <= cfg_data[CPR_W-1:0];
                REG_WINDOW: win_reg <= cfg_data[WIN_W-1:0];
                REG_MIN:    min_reg <= cfg_data[MIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Sequencer: idle, numerator product, denominator product, divide, deliver
    always_comb
    begin
        state_next     = state_reg;
        num_load       = 1'b0;
        mul_den_sel    = 1'b0;
        div_ctrl.start = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_NUM;
                end
            end
            ST_MUL_NUM:
            begin
                num_load   = 1'b1;
                state_next = ST_MUL_DEN;
            end
            ST_MUL_DEN:
            begin
                mul_den_sel    = 1'b1;
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register can take it.
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Previous count and time advance on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
        end
        else if (in_accept)
        begin
            prev_count_reg <= cnt;
            prev_time_reg  <= now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mag_reg    <= diff_mag;
            neg_reg    <= diff_neg;
            dt_reg     <= dt_clamped;
            target_reg <= target_bits;
        end
        if (num_load)
        begin
            num_reg <= NUM_W'(product);
        end
    end

    // One multiplier serves both products: mag*60000, then cpr*dt.
    assign mul_a   = mul_den_sel ? MUL_A_W'(cpr_eff) : MUL_A_W'(mag_reg);
    assign mul_b   = mul_den_sel ? dt_reg : RPM_SCALE;
    assign product = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    esm_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (div_ctrl),
        .numerator   (num_reg),
        .denominator (DEN_W'(product)),
        .stat        (div_stat),
        .quotient    (quotient)
    );

    esm_window u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .update           (in_accept),
        .now_ms           (now_ms),
        .motion           (ACC_W'(diff_mag)),
        .target_nz        (target_bits != '0),
        .window_ms        (win_reg),
        .stall_min_counts (min_reg),
        .stat             (win_stat)
    );

    // Saturate the quotient to signed 16 bits and apply the sign.
    always_comb
    begin
        if (neg_reg)
        begin
            rpm_bits = (quotient > SAT_NEG) ? 16'h8000 : (~quotient[SPEED_W-1:0] + 1'b1);
        end
        else
        begin
            rpm_bits = (quotient > SAT_POS) ? 16'h7FFF : quotient[SPEED_W-1:0];
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            speed_reg   <= rpm_bits;
            otarget_reg <= target_reg;
            ofault_reg  <= win_stat.fault;
            oonline_reg <= win_stat.online;
            oclosed_reg <= win_stat.closed;
        end
    end

    assign out_valid        = out_valid_reg;
    assign speed_rpm        = speed_reg;
    assign effective_target = otarget_reg;
    assign stall_fault      = ofault_reg;
    assign drive_online     = oonline_reg;
    assign window_closed    = oclosed_reg;

    // An accepted item always starts the multiply step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_MUL_NUM)
        else $error("accepted item did not start the multiply step");

    // The divider only finishes while the sequencer waits on it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    // A new result shows up only out of the deliver step.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output became valid without a finished item");

endmodule

`default_nettype wire

// File: sv/esm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module esm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire esm_pkg::esm_div_ctrl_t     ctrl,
    input  wire logic [esm_pkg::NUM_W-1:0]  numerator,
    input  wire logic [esm_pkg::DEN_W-1:0]  denominator,
    output esm_pkg::esm_div_stat_t          stat,
    output logic [esm_pkg::NUM_W-1:0]       quotient
);
    import esm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    // Shift in the next numerator bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = denominator;
            quo_next  = numerator;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: sv/esm_window.sv
// Stall window tracking: motion accumulator, window timer, fault, online and closed flags.
`default_nettype none

module esm_window (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        update,
    input  wire logic [esm_pkg::TIME_W-1:0]  now_ms,
    input  wire logic [esm_pkg::ACC_W-1:0]   motion,
    input  wire logic                        target_nz,
    input  wire logic [esm_pkg::WIN_W-1:0]   window_ms,
    input  wire logic [esm_pkg::MIN_W-1:0]   stall_min_counts,
    output esm_pkg::esm_win_stat_t           stat
);
    import esm_pkg::*;

    logic [TIME_W-1:0] start_reg, start_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              fault_reg, fault_next;
    logic              online_reg, online_next;
    logic              closed_reg, closed_next;
    logic [TIME_W-1:0] elapsed;
    logic [ACC_W-1:0]  acc_sum;
    logic              window_over;
    logic              enough;

    assign elapsed     = now_ms - start_reg;
    assign window_over = elapsed >= TIME_W'(window_ms);
    assign acc_sum     = acc_reg + motion;
    assign enough      = acc_sum >= stall_min_counts;

    always_comb
    begin
        start_next  = start_reg;
        acc_next    = acc_reg;
        fault_next  = fault_reg;
        online_next = online_reg;
        closed_next = closed_reg;
        if (update)
        begin
            acc_next    = acc_sum;
            closed_next = window_over;
            if (window_over)
            begin
                // Set the fault on a stalled command, drop it when the target is zero.
                if (target_nz && !enough)
                begin
                    fault_next = 1'b1;
                end
                else if (!target_nz)
                begin
                    fault_next = 1'b0;
                end
                online_next = target_nz && enough;
                acc_next    = '0;
                start_next  = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            acc_reg    <= '0;
            fault_reg  <= 1'b0;
            online_reg <= 1'b0;
            closed_reg <= 1'b0;
        end
        else
        begin
            start_reg  <= start_next;
            acc_reg    <= acc_next;
            fault_reg  <= fault_next;
            online_reg <= online_next;
            closed_reg <= closed_next;
        end
    end

    assign stat.fault  = fault_reg;
    assign stat.online = online_reg;
    assign stat.closed = closed_reg;

endmodule

`default_nettype wire

// File: dv/tb_encoder_speed_and_stall_monitor.sv
// Testbench for the encoder speed and stall monitor: random traffic against a built-in predictor.
`default_nettype none

module tb_encoder_speed_and_stall_monitor;

    import esm_pkg::*;

    // Scale from counts per ms to rpm, and the cap on the elapsed time.
    localparam longint unsigned RPM_FACTOR = 60000;
    localparam logic [15:0]     DT_CLAMP   = 16'hFFFF;

    // One control tick as it goes onto the input channel.
    typedef struct {
        logic [15:0]        count;
        logic [31:0]        now;
        logic               link;
        logic signed [15:0] cmd;
        logic               wait_drain;   // hold this tick until every reading is back
    } tick_item_t;

    // One speed reading as it comes off the output channel.
    typedef struct {
        logic signed [15:0] speed;
        logic signed [15:0] target;
        logic               fault;
        logic               online;
        logic               closed;
    } speed_reading_t;

    // Clock, reset and every block input start at known values.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [15:0]        encoder_count = '0;
    logic [31:0]        now_ms = '0;
    logic               link_ok = 1'b0;
    logic signed [15:0] commanded_speed = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] effective_target;
    logic               stall_fault;
    logic               drive_online;
    logic               window_closed;

    logic               cfg_write = 1'b0;
    cfg_idx_t           cfg_index = REG_CPR;
    logic [CFG_W-1:0]   cfg_data = '0;

    encoder_speed_and_stall_monitor DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .encoder_count    (encoder_count),
        .now_ms           (now_ms),
        .link_ok          (link_ok),
        .commanded_speed  (commanded_speed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .speed_rpm        (speed_rpm),
        .effective_target (effective_target),
        .stall_fault      (stall_fault),
        .drive_online     (drive_online),
        .window_closed    (window_closed),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the block's registers and history.
    // ------------------------------------------------------------------
    logic [CPR_W-1:0] rev_counts  = 13'd44;
    logic [15:0]      window_len  = 16'd500;
    logic [15:0]      min_motion  = 16'd3;

    logic [15:0] last_count    = '0;
    logic [31:0] last_time     = '0;
    logic [31:0] window_origin = '0;
    logic [15:0] motion_sum    = '0;
    logic        fault_held    = 1'b0;
    logic        online_held   = 1'b0;

    // Queues between stimulus, driver and checker.
    tick_item_t     tick_queue[$];
    speed_reading_t expected_readings[$];

    int unsigned ticks_sent    = 0;
    int unsigned ticks_taken   = 0;
    int unsigned readings_seen = 0;
    int unsigned n_errors      = 0;
    int unsigned n_closed      = 0;
    int unsigned n_faulted     = 0;
    int unsigned n_saturated   = 0;
    int unsigned n_settings    = 1;

    // Generator position: the stimulus continues from the last tick queued.
    logic [15:0] gen_count = '0;
    logic [31:0] gen_time  = '0;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // Advance the predictor by one tick and return the reading it should give.
    function automatic speed_reading_t predict_reading(input logic [15:0] cnt,
                                                       input logic [31:0] now,
                                                       input logic lnk,
                                                       input logic [15:0] cmd);
        logic [15:0]     delta;
        logic            backward;
        logic [16:0]     magnitude;
        logic [31:0]     elapsed;
        logic [15:0]     dt;
        logic [CPR_W-1:0] cpr;
        longint unsigned quo;
        logic            tgt_nz;
        logic            moving;
        speed_reading_t  r;

        // Wrapped count difference as sign and magnitude.
        delta     = cnt - last_count;
        backward  = delta[15];
        magnitude = backward ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
        last_count = cnt;

        // Elapsed time: zero counts as one, long gaps clamp.
        elapsed   = now - last_time;
        last_time = now;
        if (elapsed == 32'd0)
            dt = 16'd1;
        else if (elapsed > {16'd0, DT_CLAMP})
            dt = DT_CLAMP;
        else
            dt = elapsed[15:0];

        cpr = (rev_counts == '0) ? CPR_W'(1) : rev_counts;
        quo = (64'(magnitude) * RPM_FACTOR) / (64'(cpr) * 64'(dt));

        // Saturate toward the signed 16-bit limits.
        if (backward)
        begin
            if (quo > 64'd32768)
                quo = 64'd32768;
            r.speed = 16'(64'd0 - quo);
        end
        else
        begin
            if (quo > 64'd32767)
                quo = 64'd32767;
            r.speed = 16'(quo);
        end

        r.target = lnk ? cmd : 16'sd0;
        tgt_nz   = (r.target != 16'sd0);

        motion_sum = motion_sum + magnitude[15:0];

        r.closed = ((now - window_origin) >= {16'd0, window_len});
        if (r.closed)
        begin
            moving = (motion_sum >= min_motion);
            if (tgt_nz && !moving)
                fault_held = 1'b1;
            else if (!tgt_nz)
                fault_held = 1'b0;
            online_held   = tgt_nz && moving;
            motion_sum    = '0;
            window_origin = now;
        end

        r.fault  = fault_held;
        r.online = online_held;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge, in bursts with random gaps.
    // ------------------------------------------------------------------
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    tick_item_t  next_tick;
    logic        send_now;

    always @(negedge clk)
    begin
        // Hold the current item while it has not been taken.
        if (rst_n && !(in_valid && ticks_taken != ticks_sent))
        begin
            send_now = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (tick_queue.size() > 0 &&
                     !(tick_queue[0].wait_drain && expected_readings.size() > 0))
            begin
                next_tick = tick_queue.pop_front();
                send_now  = 1'b1;
                ticks_sent++;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // Pick the next burst and the pause that precedes it; the long
                    // pauses outlast the divider so gaps land on every phase.
                    burst_left = $urandom_range(1, 16);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(1, 4);
                        2:       gap_left = $urandom_range(5, 40);
                        default: gap_left = $urandom_range(30, 80);
                    endcase
                end
            end
            in_valid <= send_now;
            if (send_now)
            begin
                encoder_count   <= next_tick.count;
                now_ms          <= next_tick.now;
                link_ok         <= next_tick.link;
                commanded_speed <= next_tick.cmd;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: quiet stretches, short flicker and long holds.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned free_left  = 0;

    always @(negedge clk)
    begin
        if (stall_left == 0 && free_left == 0)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    stall_left = 0;
                    free_left  = $urandom_range(50, 300);
                end
                1:
                begin
                    stall_left = $urandom_range(1, 3);
                    free_left  = $urandom_range(1, 3);
                end
                2:
                begin
                    stall_left = $urandom_range(20, 90);
                    free_left  = $urandom_range(1, 10);
                end
                default:
                begin
                    stall_left = $urandom_range(1, 40);
                    free_left  = $urandom_range(1, 40);
                end
            endcase
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            free_left--;
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge; track register writes, predict
    // accepted ticks and check each reading against the oldest prediction.
    // ------------------------------------------------------------------
    speed_reading_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CPR:    rev_counts = cfg_data[CPR_W-1:0];
                    REG_WINDOW: window_len = cfg_data[15:0];
                    REG_MIN:    min_motion = cfg_data[15:0];
                    default:    ;
                endcase
            end

            // Check the output first so a stray reading never pairs with this
            // cycle's new prediction.
            if (out_valid && !out_stall)
            begin
                readings_seen++;
                if (expected_readings.size() == 0)
                    flag_error($sformatf("reading %0d arrived with nothing expected",
                                         readings_seen));
                else
                begin
                    want = expected_readings.pop_front();
                    if (speed_rpm !== want.speed)
                        flag_error($sformatf("reading %0d speed_rpm %0d, expected %0d",
                                             readings_seen, speed_rpm, want.speed));
                    if (effective_target !== want.target)
                        flag_error($sformatf("reading %0d effective_target %0d, expected %0d",
                                             readings_seen, effective_target, want.target));
                    if (stall_fault !== want.fault)
                        flag_error($sformatf("reading %0d stall_fault %b, expected %b",
                                             readings_seen, stall_fault, want.fault));
                    if (drive_online !== want.online)
                        flag_error($sformatf("reading %0d drive_online %b, expected %b",
                                             readings_seen, drive_online, want.online));
                    if (window_closed !== want.closed)
                        flag_error($sformatf("reading %0d window_closed %b, expected %b",
                                             readings_seen, window_closed, want.closed));
                    if (want.closed)
                        n_closed++;
                    if (want.closed && want.fault)
                        n_faulted++;
                    if (want.speed == 16'sh7FFF || want.speed == -16'sh8000)
                        n_saturated++;
                end
            end

            if (in_valid && !in_stall)
            begin
                expected_readings.push_back(predict_reading(encoder_count, now_ms,
                                                            link_ok, commanded_speed));
                ticks_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic add_tick(input logic [15:0] cnt, input logic [31:0] now,
                            input logic lnk, input logic signed [15:0] cmd,
                            input logic drain);
        tick_item_t t;
        t.count      = cnt;
        t.now        = now;
        t.link       = lnk;
        t.cmd        = cmd;
        t.wait_drain = drain;
        tick_queue.push_back(t);
        gen_count = cnt;
        gen_time  = now;
    endtask

    // Hold until every queued tick is taken and every reading is back.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || ticks_taken != ticks_sent ||
               expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // One register setting followed by segments of steady motion with noise.
    task automatic run_phase(input logic [CFG_W-1:0] cpr, input logic [CFG_W-1:0] win,
                             input logic [CFG_W-1:0] min_cnt, input int unsigned n_ticks,
                             input logic near_wrap);
        int                 seg_left;
        int                 vel;
        int                 dt_ms;
        int                 cnt;
        logic [31:0]        tm;
        logic               seg_link;
        logic               lnk;
        logic signed [15:0] seg_cmd;

        set_reg(REG_CPR, cpr);
        set_reg(REG_WINDOW, win);
        set_reg(REG_MIN, min_cnt);
        @(negedge clk);
        cfg_write <= 1'b0;
        n_settings++;

        if (near_wrap)
            gen_time = 32'hFFFF_FF80;
        seg_left = 0;
        vel      = 0;
        seg_link = 1'b1;
        seg_cmd  = '0;
        for (int i = 0; i < n_ticks; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(3, 15);
                vel      = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 80)) - 40;
                case ($urandom_range(0, 3))
                    0:       seg_cmd = '0;
                    1:       seg_cmd = 16'($urandom);
                    default: seg_cmd = 16'(int'($urandom_range(0, 6000)) - 3000);
                endcase
                seg_link = ($urandom_range(0, 7) != 0);
            end
            seg_left--;

            dt_ms = $urandom_range(1, 20);
            cnt   = int'(gen_count) + vel * dt_ms + int'($urandom_range(0, 4)) - 2;
            tm    = gen_time + 32'(dt_ms);
            lnk   = seg_link;
            // Roughly three ticks in eight break the steady pattern.
            case ($urandom_range(0, 15))
                0: tm  = gen_time;
                1: tm  = gen_time + $urandom_range(65536, 200000);
                2: tm  = $urandom;
                3: cnt = int'($urandom_range(0, 65535));
                4: cnt = int'(gen_count) + 32768;
                5: lnk = ~seg_link;
                default: ;
            endcase
            add_tick(16'(cnt), tm, lnk, seg_cmd, $urandom_range(0, 40) == 0);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings (44 counts/rev, 500 ms, 3 counts).
        add_tick(16'h0000, 32'd0, 1'b1, 16'sd0, 1'b0);          // first tick, zero elapsed time
        add_tick(16'h0001, 32'd1, 1'b1, 16'sd100, 1'b0);        // one count in one ms
        add_tick(16'h0065, 32'd1, 1'b1, 16'sh7FFF, 1'b0);       // zero dt, fast forward: clip high
        add_tick(16'h0001, 32'd2, 1'b1, -16'sh8000, 1'b0);      // fast reverse: clip low
        add_tick(16'h8001, 32'd3, 1'b0, 16'sd500, 1'b0);        // half-range step, link down
        add_tick(16'h8000, 32'd100003, 1'b1, 16'sd5, 1'b0);     // long gap clamps dt; window closes
        add_tick(16'h8000, 32'd100603, 1'b1, 16'sd5, 1'b1);     // no motion: stall sets the fault
        add_tick(16'h8010, 32'd100700, 1'b1, 16'sd5, 1'b0);     // open window holds the flags
        add_tick(16'h8010, 32'd101200, 1'b1, 16'sd5, 1'b0);     // enough motion: fault stays sticky
        add_tick(16'h8010, 32'd101800, 1'b0, 16'sd7, 1'b0);     // zero target clears the fault
        add_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b1, -16'sd1, 1'b0);
        add_tick(16'h0000, 32'h0000_0005, 1'b1, 16'sd1, 1'b0);  // time and count both wrap
        add_tick(16'h7FFF, 32'd6, 1'b1, 16'sh5555, 1'b0);       // largest forward step
        add_tick(16'hAAAA, 32'd1006, 1'b1, 16'shAAAA, 1'b0);
        add_tick(16'h5555, 32'h5555_5555, 1'b0, 16'sh5555, 1'b0);
        add_tick(16'hAAAA, 32'hAAAA_AAAA, 1'b1, -16'sh8000, 1'b0);
        wait_idle();

        // Register settings: default counts per rev with a short window, smallest, the zero cases (counts per rev
        // treated as one, every tick closes a window), the largest window and minimum, a middle set, then random.
        run_phase(16'd44, 16'd50, 16'd3, 70, 1'b0);
        run_phase(16'd1, 16'd1, 16'd0, 70, 1'b0);
        run_phase(16'd0, 16'd0, 16'hFFFF, 60, 1'b0);
        run_phase(16'd4096, 16'hFFFF, 16'hFFFF, 60, 1'b1);
        run_phase(16'd100, 16'd100, 16'd200, 80, 1'b0);
        repeat (3)
            run_phase(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 300)),
                      16'($urandom_range(0, 500)), 80, 1'b0);

        // Let any stray reading surface before the verdict.
        repeat (60) @(posedge clk);
        if (expected_readings.size() != 0)
            flag_error($sformatf("%0d readings never arrived", expected_readings.size()));

        $display("Run covered %0d ticks over %0d register settings, %0d readings checked.",
                 ticks_taken, n_settings, readings_seen);
        $display("Windows closed: %0d (%0d with a stall fault); saturated speeds: %0d.",
                 n_closed, n_faulted, n_saturated);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: ends a hung run.
    initial
    begin
        #2000000;
        $display("ERROR: timeout with %0d ticks queued and %0d readings outstanding",
                 tick_queue.size(), expected_readings.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
